/* hw/rtl/can_safety_frame_timing_monitor_defines.svh */
// Assertion helpers used by the assertion module csftm_sva.
// Each macro expects signals named clk and rst in scope.
`ifndef CAN_SAFETY_FRAME_TIMING_MONITOR_DEFINES_SVH
`define CAN_SAFETY_FRAME_TIMING_MONITOR_DEFINES_SVH

// Same-cycle implication.
`define CSFTM_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("csftm check failed");

// Next-cycle implication.
`define CSFTM_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("csftm check failed");

`endif

/* hw/rtl/csftm_pkg.sv */
package csftm_pkg;

  // Fixed field widths
  localparam int ID_W    = 11;
  localparam int TS_W    = 32;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 48;
  localparam int WIDE_W  = 48;
  localparam int CFG_W   = 32;
  localparam int REG_IDX_W = 2;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // Register indexes
  localparam reg_idx_t REG_SAFETY_ID   = 2'd0;
  localparam reg_idx_t REG_INVERSE_ID  = 2'd1;
  localparam reg_idx_t REG_CYCLE_LIMIT = 2'd2;
  localparam reg_idx_t REG_VALID_LIMIT = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_CYCLE = 2'd1;
  localparam logic [1:0] STATUS_VALID = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0] safety_id;
    logic [ID_W-1:0] inverse_id;
    logic [TS_W-1:0] cycle_limit;
    logic [TS_W-1:0] validation_limit;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0] frame_id;
    logic [TS_W-1:0] arrival_time;
  } frame_word_t;

  typedef struct packed {
    logic [TS_W-1:0]  gap;
    logic [1:0]       status;
    logic [CNT_W-1:0] frame_total;
    logic [CNT_W-1:0] error_total;
    logic [CNT_W-1:0] cycle_count;
    logic [TS_W-1:0]  cycle_min;
    logic [TS_W-1:0]  cycle_max;
    logic [SUM_W-1:0] cycle_sum;
    logic [CNT_W-1:0] valid_count;
    logic [TS_W-1:0]  valid_min;
    logic [TS_W-1:0]  valid_max;
    logic [SUM_W-1:0] valid_sum;
  } report_word_t;

  // One classified frame headed for the statistics stage
  typedef struct packed {
    logic [TS_W-1:0]   gap;
    logic [1:0]        status;
    logic              rec_cycle;
    logic              rec_valid;
    logic [WIDE_W-1:0] value;
  } stat_item_t;

endpackage

/* hw/rtl/csftm_cfg.sv */
module csftm_cfg
  import csftm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  reg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  // Register file write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.safety_id        <= ID_W'(1);
      cfg.inverse_id       <= ID_W'(2);
      cfg.cycle_limit      <= '0;
      cfg.validation_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAFETY_ID:   cfg.safety_id        <= cfg_data[ID_W-1:0];
        REG_INVERSE_ID:  cfg.inverse_id       <= cfg_data[ID_W-1:0];
        REG_CYCLE_LIMIT: cfg.cycle_limit      <= cfg_data[TS_W-1:0];
        REG_VALID_LIMIT: cfg.validation_limit <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/csftm_table.sv */
module csftm_table
  import csftm_pkg::*;
#(
  parameter int ID_BITS   = 11,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [ID_BITS-1:0]   rd_addr_a,
  input  logic [ID_BITS-1:0]   rd_addr_b,
  output logic [TIME_BITS:0]   rd_a,
  output logic [TIME_BITS:0]   rd_b,
  input  logic                 wr_en,
  input  logic [ID_BITS-1:0]   wr_addr,
  input  logic [TIME_BITS-1:0] wr_time,
  output logic                 ready
);

  localparam int DEPTH = 1 << ID_BITS;

  // Entry: top bit is the seen flag, the rest the last arrival time
  logic [TIME_BITS:0] mem [DEPTH];

  logic               clearing;
  logic [ID_BITS-1:0] clr_addr;

  // Sweep after reset clears every seen flag, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  assign ready = !clearing;

  // Single write port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {1'b1, wr_time};
    end
  end

  // Two registered read ports, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end

endmodule

/* hw/rtl/csftm_stats.sv */
module csftm_stats
  import csftm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         upd,
  input  stat_item_t   item,
  output report_word_t report
);

  logic [CNT_W-1:0] frames, errors, c_cnt, v_cnt;
  logic [TS_W-1:0]  c_min, c_max, v_min, v_max;
  logic [SUM_W-1:0] c_sum, v_sum;

  logic [CNT_W-1:0] frames_next, errors_next, c_cnt_next, v_cnt_next;
  logic [TS_W-1:0]  c_min_next, c_max_next, v_min_next, v_max_next;
  logic [SUM_W-1:0] c_sum_next, v_sum_next;

  logic [TS_W-1:0]  clamped;
  logic [SUM_W:0]   c_add, v_add;

  // Min/max see the value clamped to 32 bits; sums take it whole
  assign clamped = (|item.value[WIDE_W-1:TS_W]) ? '1 : item.value[TS_W-1:0];
  assign c_add   = {1'b0, c_sum} + {1'b0, SUM_W'(item.value)};
  assign v_add   = {1'b0, v_sum} + {1'b0, SUM_W'(item.value)};

  always_comb begin
    frames_next = (frames == '1) ? frames : frames + 1'b1;
    errors_next = errors;
    if (item.status != STATUS_OK && errors != '1) begin
      errors_next = errors + 1'b1;
    end

    c_cnt_next = c_cnt;
    c_min_next = c_min;
    c_max_next = c_max;
    c_sum_next = c_sum;
    if (item.rec_cycle) begin
      c_cnt_next = (c_cnt == '1) ? c_cnt : c_cnt + 1'b1;
      c_min_next = (clamped < c_min) ? clamped : c_min;
      c_max_next = (clamped > c_max) ? clamped : c_max;
      c_sum_next = c_add[SUM_W] ? '1 : c_add[SUM_W-1:0];
    end

    v_cnt_next = v_cnt;
    v_min_next = v_min;
    v_max_next = v_max;
    v_sum_next = v_sum;
    if (item.rec_valid) begin
      v_cnt_next = (v_cnt == '1) ? v_cnt : v_cnt + 1'b1;
      v_min_next = (clamped < v_min) ? clamped : v_min;
      v_max_next = (clamped > v_max) ? clamped : v_max;
      v_sum_next = v_add[SUM_W] ? '1 : v_add[SUM_W-1:0];
    end
  end

  // Running totals and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      frames <= '0;
      errors <= '0;
      c_cnt  <= '0;
      c_min  <= '1;
      c_max  <= '0;
      c_sum  <= '0;
      v_cnt  <= '0;
      v_min  <= '1;
      v_max  <= '0;
      v_sum  <= '0;
    end else if (upd) begin
      frames <= frames_next;
      errors <= errors_next;
      c_cnt  <= c_cnt_next;
      c_min  <= c_min_next;
      c_max  <= c_max_next;
      c_sum  <= c_sum_next;
      v_cnt  <= v_cnt_next;
      v_min  <= v_min_next;
      v_max  <= v_max_next;
      v_sum  <= v_sum_next;
    end
  end

  // Output word register, loaded with the post-update values
  always_ff @(posedge clk) begin
    if (upd) begin
      report.gap         <= item.gap;
      report.status      <= item.status;
      report.frame_total <= frames_next;
      report.error_total <= errors_next;
      report.cycle_count <= c_cnt_next;
      report.cycle_min   <= c_min_next;
      report.cycle_max   <= c_max_next;
      report.cycle_sum   <= c_sum_next;
      report.valid_count <= v_cnt_next;
      report.valid_min   <= v_min_next;
      report.valid_max   <= v_max_next;
      report.valid_sum   <= v_sum_next;
    end
  end

endmodule

/* hw/rtl/can_safety_frame_timing_monitor.sv */
// Path: stage 1 (table read), stage 2 (limit checks), stage 3 (statistics) and the report register.
// Throughput: one frame per cycle while frame_stall stays low; the ID table has two read ports and one
// write port, and a write still in flight is forwarded to the next frame.
// Reset: synchronous; a sweep then clears every ID table entry
// with frame_stall high; config writes are taken meanwhile.
module can_safety_frame_timing_monitor
  import csftm_pkg::*;
#(
  parameter int ID_BITS   = 11,
  parameter int TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  reg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             frame_valid,
  output logic             frame_stall,
  input  frame_word_t      frame,
  output logic             report_valid,
  input  logic             report_stall,
  output report_word_t     report
);

  cfg_t cfg;
  logic table_ready;

  csftm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage valids and moves
  logic v1, v2, v3, vo;
  logic mv1, mv2, mv3, acc;

  assign mv3 = v3 && (!vo || !report_stall);
  assign mv2 = v2 && (!v3 || mv3);
  assign mv1 = v1 && (!v2 || mv2);
  assign frame_stall = !table_ready || (v1 && !mv1);
  assign acc = frame_valid && !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      v1 <= acc || (v1 && !mv1);
      v2 <= mv1 || (v2 && !mv2);
      v3 <= mv2 || (v3 && !mv3);
      vo <= mv3 || (vo && report_stall);
    end
  end

  assign report_valid = vo;

  // Table lookup issue
  logic [ID_BITS-1:0]   slot, ns_slot;
  logic [TIME_BITS-1:0] t_in;
  logic [TIME_BITS:0]   rd_own, rd_ns;

  assign slot    = frame.frame_id[ID_BITS-1:0];
  assign ns_slot = cfg.safety_id[ID_BITS-1:0];
  assign t_in    = TIME_BITS'(WIDE_W'(frame.arrival_time));

  // Stage 1: table data arrives
  logic [ID_BITS-1:0]   s1_slot;
  logic [TIME_BITS-1:0] s1_t, s1_fwd_t;
  logic                 s1_inv, s1_norm, s1_fwd_own, s1_fwd_ns, s1_same;

  csftm_table #(
    .ID_BITS   (ID_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (acc),
    .rd_addr_a (slot),
    .rd_addr_b (ns_slot),
    .rd_a      (rd_own),
    .rd_b      (rd_ns),
    .wr_en     (mv1),
    .wr_addr   (s1_slot),
    .wr_time   (s1_t),
    .ready     (table_ready)
  );

  // The stage-1 frame writes at the accept edge, so its entry is forwarded
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_slot    <= slot;
      s1_t       <= t_in;
      s1_inv     <= (frame.frame_id == cfg.inverse_id);
      s1_norm    <= (frame.frame_id == cfg.safety_id);
      s1_fwd_own <= v1 && (s1_slot == slot);
      s1_fwd_ns  <= v1 && (s1_slot == ns_slot);
      s1_fwd_t   <= s1_t;
      s1_same    <= (slot == ns_slot);
    end
  end

  logic                 own_seen, ns_seen;
  logic [TIME_BITS-1:0] own_t, ns_t, gap1, dv1;

  always_comb begin
    own_seen = s1_fwd_own || rd_own[TIME_BITS];
    own_t    = s1_fwd_own ? s1_fwd_t : rd_own[TIME_BITS-1:0];
    // Own entry is written before the normal-frame lookup
    if (s1_same) begin
      ns_seen = 1'b1;
      ns_t    = s1_t;
    end else if (s1_fwd_ns) begin
      ns_seen = 1'b1;
      ns_t    = s1_fwd_t;
    end else begin
      ns_seen = rd_ns[TIME_BITS];
      ns_t    = rd_ns[TIME_BITS-1:0];
    end
    gap1 = own_seen ? s1_t - own_t : '0;
    dv1  = s1_t - ns_t;
  end

  // Stage 2: limit checks
  logic [TIME_BITS-1:0] s2_gap, s2_dv;
  logic                 s2_ns_seen, s2_inv, s2_norm;

  always_ff @(posedge clk) begin
    if (mv1) begin
      s2_gap     <= gap1;
      s2_dv      <= dv1;
      s2_ns_seen <= ns_seen;
      s2_inv     <= s1_inv;
      s2_norm    <= s1_norm;
    end
  end

  logic [WIDE_W-1:0] gap_w, dv_w;
  logic              cyc_err, val_err;
  stat_item_t        item2, s3_item;

  assign gap_w   = WIDE_W'(s2_gap);
  assign dv_w    = WIDE_W'(s2_dv);
  assign cyc_err = gap_w > WIDE_W'(cfg.cycle_limit);
  assign val_err = dv_w > WIDE_W'(cfg.validation_limit);

  always_comb begin
    item2.gap       = gap_w[TS_W-1:0];
    item2.status    = STATUS_OK;
    item2.rec_valid = 1'b0;
    item2.rec_cycle = 1'b0;
    if (s2_inv) begin
      if (cyc_err) begin
        item2.status = STATUS_CYCLE;
      end else if (s2_ns_seen && val_err) begin
        item2.status = STATUS_VALID;
      end else begin
        item2.rec_valid = s2_ns_seen;
      end
    end else begin
      item2.rec_cycle = s2_norm && (s2_gap != '0);
    end
    item2.value = item2.rec_valid ? dv_w : gap_w;
  end

  // Stage 3: statistics update into the output register
  always_ff @(posedge clk) begin
    if (mv2) begin
      s3_item <= item2;
    end
  end

  csftm_stats u_stats (
    .clk    (clk),
    .rst    (rst),
    .upd    (mv3),
    .item   (s3_item),
    .report (report)
  );

endmodule

/* hw/rtl/csftm_sva.sv */
`include "can_safety_frame_timing_monitor_defines.svh"

module csftm_sva
  import csftm_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         report_valid,
  input logic         report_stall,
  input report_word_t report
);

  logic [CNT_W-1:0] prev_frames, prev_errors;
  logic [CNT_W-1:0] exp_frames, exp_errors;
  logic             rep_acc, frames_ok, errors_ok, order_ok;

  assign rep_acc = report_valid && !report_stall;

  // Totals from the last delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_frames <= '0;
      prev_errors <= '0;
    end else if (rep_acc) begin
      prev_frames <= report.frame_total;
      prev_errors <= report.error_total;
    end
  end

  assign exp_frames = (prev_frames == '1) ? prev_frames : prev_frames + 1'b1;
  assign exp_errors = (prev_errors == '1 || report.status == STATUS_OK) ?
                      prev_errors : prev_errors + 1'b1;
  assign frames_ok  = report.frame_total == exp_frames;
  assign errors_ok  = report.error_total == exp_errors;
  assign order_ok   = (report.cycle_count == '0 || report.cycle_min <= report.cycle_max) &&
                      (report.valid_count == '0 || report.valid_min <= report.valid_max);

  `CSFTM_ASSERT_NOW(a_frame_total_steps, rep_acc, frames_ok)
  `CSFTM_ASSERT_NOW(a_error_total_tracks_status, rep_acc, errors_ok)
  `CSFTM_ASSERT_NOW(a_min_not_above_max, report_valid, order_ok)
  `CSFTM_ASSERT_NEXT(a_stalled_word_holds, report_valid && report_stall,
                     report_valid && $stable(report))

endmodule

bind can_safety_frame_timing_monitor csftm_sva u_csftm_sva (.*);

/* verif/csftm_checker.sv */
module csftm_checker
  import csftm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  reg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             frame_valid,
  input  logic             frame_stall,
  input  frame_word_t      frame,
  input  logic             report_valid,
  input  logic             report_stall,
  input  report_word_t     report,
  output int unsigned      mismatch_total,
  output int unsigned      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 1 << ID_W;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // min/max/sum/count set kept for cycle gaps and validation intervals
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [TS_W-1:0]  min_v;
    logic [TS_W-1:0]  max_v;
    logic [SUM_W-1:0] sum;
  } interval_stats_t;

  localparam interval_stats_t STATS_CLEAR = '{
    count: '0, min_v: {TS_W{1'b1}}, max_v: '0, sum: '0
  };

  // shadow of the register file
  logic [ID_W-1:0] normal_id;
  logic [ID_W-1:0] inverted_id;
  logic [TS_W-1:0] cycle_lim;
  logic [TS_W-1:0] valid_lim;

  // per-ID arrival table and running totals
  logic [TS_W-1:0]  last_time [TABLE_DEPTH];
  logic             seen      [TABLE_DEPTH];
  logic [CNT_W-1:0] frames_total;
  logic [CNT_W-1:0] errors_total;
  interval_stats_t  cycle_stats;
  interval_stats_t  valid_stats;

  report_word_t expected_reports [$];

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic interval_stats_t fold_interval(interval_stats_t s, logic [TS_W-1:0] v);
    if (v < s.min_v) s.min_v = v;
    if (v > s.max_v) s.max_v = v;
    // sum saturates at all ones
    if (SUM_MAX - s.sum < SUM_W'(v)) s.sum = SUM_MAX;
    else s.sum = s.sum + SUM_W'(v);
    s.count = bump(s.count);
    return s;
  endfunction

  // Updates the table and statistics for one frame, returns its report word
  function automatic report_word_t frame_timing_report(frame_word_t w);
    report_word_t    r;
    logic [TS_W-1:0] gap;
    logic [TS_W-1:0] since_normal;
    logic [1:0]      verdict;
    int unsigned     slot;
    int unsigned     normal_slot;
    slot = 32'(w.frame_id);
    normal_slot = 32'(normal_id);
    verdict = STATUS_OK;
    gap = seen[slot] ? w.arrival_time - last_time[slot] : '0;
    // own entry first, so equal IDs give a zero validation interval
    last_time[slot] = w.arrival_time;
    seen[slot] = 1'b1;
    if (w.frame_id == inverted_id) begin
      if (gap > cycle_lim) begin
        verdict = STATUS_CYCLE;
      end else if (seen[normal_slot]) begin
        since_normal = w.arrival_time - last_time[normal_slot];
        if (since_normal > valid_lim) verdict = STATUS_VALID;
        else valid_stats = fold_interval(valid_stats, since_normal);
      end
    end else if (w.frame_id == normal_id) begin
      if (gap != '0) cycle_stats = fold_interval(cycle_stats, gap);
    end
    if (verdict != STATUS_OK) errors_total = bump(errors_total);
    frames_total = bump(frames_total);
    r.gap         = gap;
    r.status      = verdict;
    r.frame_total = frames_total;
    r.error_total = errors_total;
    r.cycle_count = cycle_stats.count;
    r.cycle_min   = cycle_stats.min_v;
    r.cycle_max   = cycle_stats.max_v;
    r.cycle_sum   = cycle_stats.sum;
    r.valid_count = valid_stats.count;
    r.valid_min   = valid_stats.min_v;
    r.valid_max   = valid_stats.max_v;
    r.valid_sum   = valid_stats.sum;
    return r;
  endfunction

  task automatic report_failure(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_total++;
  endtask

  task automatic check_field(string name, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
    if (got !== want) report_failure($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      normal_id    = ID_W'(1);
      inverted_id  = ID_W'(2);
      cycle_lim    = '0;
      valid_lim    = '0;
      frames_total = '0;
      errors_total = '0;
      cycle_stats  = STATS_CLEAR;
      valid_stats  = STATS_CLEAR;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        seen[i] = 1'b0;
        last_time[i] = '0;
      end
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SAFETY_ID:   normal_id   = cfg_data[ID_W-1:0];
          REG_INVERSE_ID:  inverted_id = cfg_data[ID_W-1:0];
          REG_CYCLE_LIMIT: cycle_lim   = cfg_data[TS_W-1:0];
          REG_VALID_LIMIT: valid_lim   = cfg_data[TS_W-1:0];
          default: ;
        endcase
      end

      // outgoing word against the oldest prediction
      if (report_valid && !report_stall) begin
        if (expected_reports.size() == 0) begin
          report_failure("report word with no frame pending");
        end else begin
          report_word_t want;
          want = expected_reports.pop_front();
          check_field("gap",         SUM_W'(report.gap),         SUM_W'(want.gap));
          check_field("status",      SUM_W'(report.status),      SUM_W'(want.status));
          check_field("frame_total", SUM_W'(report.frame_total), SUM_W'(want.frame_total));
          check_field("error_total", SUM_W'(report.error_total), SUM_W'(want.error_total));
          check_field("cycle_count", SUM_W'(report.cycle_count), SUM_W'(want.cycle_count));
          check_field("cycle_min",   SUM_W'(report.cycle_min),   SUM_W'(want.cycle_min));
          check_field("cycle_max",   SUM_W'(report.cycle_max),   SUM_W'(want.cycle_max));
          check_field("cycle_sum",   report.cycle_sum,           want.cycle_sum);
          check_field("valid_count", SUM_W'(report.valid_count), SUM_W'(want.valid_count));
          check_field("valid_min",   SUM_W'(report.valid_min),   SUM_W'(want.valid_min));
          check_field("valid_max",   SUM_W'(report.valid_max),   SUM_W'(want.valid_max));
          check_field("valid_sum",   report.valid_sum,           want.valid_sum);
        end
      end

      if (frame_valid && !frame_stall) expected_reports.push_back(frame_timing_report(frame));
    end
    outstanding <= expected_reports.size();
  end

endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csftm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  reg_idx_t         cfg_index = REG_SAFETY_ID;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             frame_valid = 1'b0;
  logic             frame_stall;
  frame_word_t      frame = '0;
  logic             report_valid;
  logic             report_stall = 1'b0;
  report_word_t     report;
  int unsigned      mismatch_total;
  int unsigned      outstanding;

  // no idling on either side while set
  logic        calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;

  // limits of the current setting, used to aim intervals at the edges
  logic [TS_W-1:0] cur_cycle_lim;
  logic [TS_W-1:0] cur_valid_lim;
  logic [ID_W-1:0] cur_normal_id = ID_W'(1);
  logic [ID_W-1:0] cur_inverse_id = ID_W'(2);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  can_safety_frame_timing_monitor i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report)
  );

  csftm_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .frame_valid    (frame_valid),
    .frame_stall    (frame_stall),
    .frame          (frame),
    .report_valid   (report_valid),
    .report_stall   (report_stall),
    .report         (report),
    .mismatch_total (mismatch_total),
    .outstanding    (outstanding)
  );

  // receiver back-pressure, started at random while calm is low
  always @(posedge clk) begin
    if (stall_left != 0) begin
      report_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      report_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      report_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // all four registers back to back; upper pad bits land above the ID fields
  task automatic load_config(logic [ID_W-1:0] sid, logic [ID_W-1:0] iid,
                             logic [TS_W-1:0] clim, logic [TS_W-1:0] vlim,
                             logic [CFG_W-1:0] pad);
    cur_normal_id = sid;
    cur_inverse_id = iid;
    cur_cycle_lim = clim;
    cur_valid_lim = vlim;
    cfg_we <= 1'b1;
    cfg_index <= REG_SAFETY_ID;
    cfg_data <= {pad[CFG_W-1:ID_W], sid};
    @(posedge clk);
    cfg_index <= REG_INVERSE_ID;
    cfg_data <= {pad[CFG_W-1:ID_W], iid};
    @(posedge clk);
    cfg_index <= REG_CYCLE_LIMIT;
    cfg_data <= clim;
    @(posedge clk);
    cfg_index <= REG_VALID_LIMIT;
    cfg_data <= vlim;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(logic [ID_W-1:0] id, logic [TS_W-1:0] ts);
    if (!calm && $urandom_range(0, 4) == 0) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame <= '{frame_id: id, arrival_time: ts};
    do @(posedge clk); while (frame_stall);
  endtask

  // hold off until every report word is back
  task automatic drain();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // interval scattered around a limit so both sides of it get hit
  function automatic logic [TS_W-1:0] pick_near(logic [TS_W-1:0] lim);
    if (lim == TS_MAX) return $urandom;
    if (lim < 100_000) return $urandom_range(0, 2 * lim + 1);
    return lim - 1000 + $urandom_range(0, 2000);
  endfunction

  // mostly normal/inverse pairs with random timing, plus stray and broken frames
  task automatic run_traffic(int unsigned n_items);
    int unsigned     sent;
    int unsigned     kind;
    logic [TS_W-1:0] now;
    logic [TS_W-1:0] interval;
    sent = 0;
    now = ($urandom_range(0, 2) == 0) ? TS_MAX - $urandom_range(0, 50_000) : $urandom;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        interval = pick_near(cur_valid_lim);
        send_frame(cur_normal_id, now);
        send_frame(cur_inverse_id, now + interval);
        now = now + pick_near(cur_cycle_lim);
        sent += 2;
      end else if (kind == 6) begin
        // broken pair: lone inverse or lone normal
        if ($urandom_range(0, 1) == 0) send_frame(cur_inverse_id, now + pick_near(cur_valid_lim));
        else send_frame(cur_normal_id, now);
        now = now + pick_near(cur_cycle_lim);
        sent += 1;
      end else if (kind <= 8) begin
        send_frame(ID_W'($urandom_range(0, (1 << ID_W) - 1)), $urandom);
        sent += 1;
      end else begin
        send_frame($urandom_range(0, 1) ? cur_normal_id : cur_inverse_id, $urandom);
        sent += 1;
      end
      if ($urandom_range(0, 39) == 0) drain();
    end
    drain();
  endtask

  initial begin
    logic [ID_W-1:0] sid;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset setting: inverse first, normal first, wrapped zero gap, field extremes
    send_frame(ID_W'(2), 32'd100);
    send_frame(ID_W'(1), 32'd200);
    send_frame(ID_W'(2), 32'd250);
    send_frame(ID_W'(1), 32'd200);
    send_frame('0, '0);
    send_frame({ID_W{1'b1}}, TS_MAX);
    send_frame({ID_W{1'b1}}, 32'd5);
    drain();

    // extreme IDs and limits, wrapping intervals
    load_config({ID_W{1'b1}}, '0, TS_MAX, TS_MAX, {CFG_W{1'b1}});
    send_frame('0, 32'd10);
    send_frame({ID_W{1'b1}}, 32'd3);
    send_frame('0, 32'd2);
    drain();

    // normal and inverse share an ID
    load_config(ID_W'(5), ID_W'(5), '0, '0, '0);
    send_frame(ID_W'(5), 32'd1000);
    send_frame(ID_W'(5), 32'd1000);
    send_frame(ID_W'(5), 32'd1001);
    drain();

    // limits hit from below, at and above
    load_config(ID_W'(3), ID_W'(4), 32'd100, 32'd20, '0);
    send_frame(ID_W'(3), 32'd2000);
    send_frame(ID_W'(4), 32'd2010);
    send_frame(ID_W'(3), 32'd2100);
    send_frame(ID_W'(4), 32'd2130);
    send_frame(ID_W'(3), 32'd2200);
    send_frame(ID_W'(4), 32'd2230);
    send_frame(ID_W'(3), 32'd2300);
    send_frame(ID_W'(4), 32'd2320);
    drain();

    // random phases
    sid = ID_W'($urandom);
    load_config(sid, sid ^ ID_W'($urandom_range(1, (1 << ID_W) - 1)),
                $urandom_range(50, 500), $urandom_range(10, 100), $urandom);
    run_traffic(110);

    calm <= 1'b1;
    load_config('0, {ID_W{1'b1}}, TS_MAX, TS_MAX, $urandom);
    run_traffic(90);
    calm <= 1'b0;

    sid = ID_W'($urandom);
    load_config(sid, sid, '0, '0, $urandom);
    run_traffic(60);

    sid = ID_W'($urandom);
    load_config(sid, sid ^ ID_W'($urandom_range(1, (1 << ID_W) - 1)), $urandom, $urandom,
                $urandom);
    run_traffic(90);

    load_config({ID_W{1'b1}}, '0, 32'd200, '0, $urandom);
    run_traffic(90);

    // closing phase without idling
    calm <= 1'b1;
    sid = ID_W'($urandom);
    load_config(sid, sid ^ ID_W'($urandom_range(1, (1 << ID_W) - 1)),
                $urandom_range(20, 300), $urandom_range(5, 60), $urandom);
    run_traffic(110);

    repeat (8) @(posedge clk);
    if (mismatch_total == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/csftm_pkg.sv
hw/rtl/csftm_cfg.sv
hw/rtl/csftm_table.sv
hw/rtl/csftm_stats.sv
hw/rtl/can_safety_frame_timing_monitor.sv
hw/rtl/csftm_sva.sv
verif/csftm_checker.sv
verif/tb.sv
